// ===== rtl/pwr_pkg.sv =====
package pwr_pkg;

    localparam int WINDOW_ELEMENTS_DEF = 9;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SAMPLE_FIELDS       = 9;
    localparam int MODE_BITS           = 2;
    // quotient bits resolved by one divider stage
    localparam int DIV_STEP_BITS       = 4;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_MAX    = 2'd0,
        MODE_AVG    = 2'd1,
        MODE_MEDIAN = 2'd2,
        MODE_MIN    = 2'd3
    } pool_mode_t;

    typedef struct packed {
        logic avg;
        logic neg;
        logic empty;
    } pwr_ctrl_t;

endpackage

// ===== rtl/pwr_lane.sv =====
module pwr_lane
    import pwr_pkg::*;
#(
    parameter int WINDOW_ELEMENTS = WINDOW_ELEMENTS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int LANE_INDEX      = 0
)
(
    input  logic signed [SAMPLE_BITS-1:0]                 samples [WINDOW_ELEMENTS],
    input  logic        [WINDOW_ELEMENTS-1:0]             mask,
    output logic        [$clog2(WINDOW_ELEMENTS+1)-1:0]   rank
);

    localparam int CW = $clog2(WINDOW_ELEMENTS + 1);

    // Rank among valid samples; equal values are ordered by position so ranks are unique
    always_comb
    begin
        logic [CW-1:0] rank_v;
        rank_v = '0;
        for (int j = 0; j < WINDOW_ELEMENTS; j++)
        begin
            if (j != LANE_INDEX && mask[j])
            begin
                if (samples[j] < samples[LANE_INDEX] ||
                    (samples[j] == samples[LANE_INDEX] && j < LANE_INDEX))
                begin
                    rank_v = rank_v + CW'(1);
                end
            end
        end
        rank = rank_v;
    end

endmodule

// ===== rtl/pwr_merge.sv =====
module pwr_merge
    import pwr_pkg::*;
#(
    parameter int WINDOW_ELEMENTS = WINDOW_ELEMENTS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int QUOT_BITS       = 20
)
(
    input  pool_mode_t                                    mode,
    input  logic signed [SAMPLE_BITS-1:0]                 samples [WINDOW_ELEMENTS],
    input  logic        [WINDOW_ELEMENTS-1:0]             mask,
    input  logic        [$clog2(WINDOW_ELEMENTS+1)-1:0]   ranks [WINDOW_ELEMENTS],
    input  logic        [$clog2(WINDOW_ELEMENTS+1)-1:0]   count,
    input  logic signed [SAMPLE_BITS+$clog2(WINDOW_ELEMENTS+1)-1:0] sum,
    output pwr_ctrl_t                                     ctrl,
    output logic signed [SAMPLE_BITS-1:0]                 value,
    output logic        [QUOT_BITS-1:0]                   qd,
    output logic        [$clog2(WINDOW_ELEMENTS+1)-1:0]   div
);

    localparam int CW = $clog2(WINDOW_ELEMENTS + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int MW = SW - 1;

    always_comb
    begin
        logic [CW-1:0]          target;
        logic [SAMPLE_BITS-1:0] sel;
        logic [SW-1:0]          mag;
        unique case (mode)
            MODE_MAX:    target = count - CW'(1);
            MODE_MEDIAN: target = count >> 1;
            MODE_MIN:    target = '0;
            MODE_AVG:    target = '0;
            default:     target = '0;
        endcase
        // exactly one valid lane holds the target rank when the window is not empty
        sel = '0;
        for (int i = 0; i < WINDOW_ELEMENTS; i++)
        begin
            if (mask[i] && ranks[i] == target)
            begin
                sel = sel | samples[i];
            end
        end
        mag = sum[SW-1] ? -sum : sum;

        ctrl.avg   = (mode == MODE_AVG);
        ctrl.neg   = sum[SW-1];
        ctrl.empty = (count == '0);
        value      = sel;
        qd         = QUOT_BITS'(mag[MW-1:0]);
        div        = count;
    end

endmodule

// ===== rtl/pwr_div_stage.sv =====
module pwr_div_stage
    import pwr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int QUOT_BITS   = 20,
    parameter int COUNT_BITS  = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          ready,
    input  pwr_ctrl_t                     in_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] in_value,
    input  logic [QUOT_BITS-1:0]          in_qd,
    input  logic [COUNT_BITS-1:0]         in_rem,
    input  logic [COUNT_BITS-1:0]         in_div,
    output logic                          out_valid,
    input  logic                          take,
    output pwr_ctrl_t                     out_ctrl,
    output logic signed [SAMPLE_BITS-1:0] out_value,
    output logic [QUOT_BITS-1:0]          out_qd,
    output logic [COUNT_BITS-1:0]         out_rem,
    output logic [COUNT_BITS-1:0]         out_div
);

    logic                          valid_reg;
    pwr_ctrl_t                     ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic [QUOT_BITS-1:0]          qd_reg;
    logic [COUNT_BITS-1:0]         rem_reg;
    logic [COUNT_BITS-1:0]         div_reg;
    logic [QUOT_BITS-1:0]          qd_next;
    logic [COUNT_BITS-1:0]         rem_next;

    // Restoring division: dividend shifts out the top, quotient bits shift in at the bottom
    always_comb
    begin
        logic [QUOT_BITS-1:0]  qd_v;
        logic [COUNT_BITS:0]   part;
        logic [COUNT_BITS-1:0] rem_v;
        qd_v  = in_qd;
        rem_v = in_rem;
        for (int s = 0; s < DIV_STEP_BITS; s++)
        begin
            part = {rem_v, qd_v[QUOT_BITS-1]};
            qd_v = qd_v << 1;
            if (part >= {1'b0, in_div})
            begin
                part    = part - {1'b0, in_div};
                qd_v[0] = 1'b1;
            end
            rem_v = part[COUNT_BITS-1:0];
        end
        qd_next  = qd_v;
        rem_next = rem_v;
    end

    assign ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            ctrl_reg  <= in_ctrl;
            value_reg <= in_value;
            qd_reg    <= qd_next;
            rem_reg   <= rem_next;
            div_reg   <= in_div;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_value = value_reg;
    assign out_qd    = qd_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;

endmodule

// ===== rtl/pooling_window_reducer.sv =====
// Pooling window reducer: takes one window of up to nine signed samples per cycle and
// returns its max, average (truncated toward zero), median (upper middle for even counts)
// or min over the samples whose mask bit is set; an empty window gives 0 with window_empty.
// Throughput is one window per clock cycle while res_stall is low; win_stall holds off the
// sender otherwise. A window passes stage 1, stage 2, the divider stages and the output
// register; the pipelined divider for the average resolves four quotient bits per stage,
// and all modes travel the same pipeline so results stay in order.
// pool_mode is to be written only while no transaction is in flight.
module pooling_window_reducer
    import pwr_pkg::*;
#(
    parameter int WINDOW_ELEMENTS = WINDOW_ELEMENTS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pool_mode_we,
    input  logic [MODE_BITS-1:0]          pool_mode_wdata,
    input  logic                          win_valid,
    output logic                          win_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_0,
    input  logic signed [SAMPLE_BITS-1:0] sample_1,
    input  logic signed [SAMPLE_BITS-1:0] sample_2,
    input  logic signed [SAMPLE_BITS-1:0] sample_3,
    input  logic signed [SAMPLE_BITS-1:0] sample_4,
    input  logic signed [SAMPLE_BITS-1:0] sample_5,
    input  logic signed [SAMPLE_BITS-1:0] sample_6,
    input  logic signed [SAMPLE_BITS-1:0] sample_7,
    input  logic signed [SAMPLE_BITS-1:0] sample_8,
    input  logic [SAMPLE_FIELDS-1:0]      valid_mask,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic signed [SAMPLE_BITS-1:0] pooled_value,
    output logic                          window_empty
);

    localparam int CW = $clog2(WINDOW_ELEMENTS + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int MW = SW - 1;
    localparam int ND = (MW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int QW = ND * DIV_STEP_BITS;

    pool_mode_t pool_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_mode_reg <= MODE_MAX;
        end
        else if (pool_mode_we)
        begin
            pool_mode_reg <= pool_mode_t'(pool_mode_wdata);
        end
    end

    // Input window
    logic signed [SAMPLE_BITS-1:0] field_sample [SAMPLE_FIELDS];
    logic signed [SAMPLE_BITS-1:0] win_sample [WINDOW_ELEMENTS];
    logic [WINDOW_ELEMENTS-1:0]    win_mask;
    logic [CW-1:0]                 lane_rank [WINDOW_ELEMENTS];
    logic [CW-1:0]                 win_count;
    logic signed [SW-1:0]          win_sum;

    assign field_sample[0] = sample_0;
    assign field_sample[1] = sample_1;
    assign field_sample[2] = sample_2;
    assign field_sample[3] = sample_3;
    assign field_sample[4] = sample_4;
    assign field_sample[5] = sample_5;
    assign field_sample[6] = sample_6;
    assign field_sample[7] = sample_7;
    assign field_sample[8] = sample_8;
    assign win_mask        = valid_mask[WINDOW_ELEMENTS-1:0];

    for (genvar i = 0; i < WINDOW_ELEMENTS; i++)
    begin : g_lane
        assign win_sample[i] = field_sample[i];

        pwr_lane #(
            .WINDOW_ELEMENTS (WINDOW_ELEMENTS),
            .SAMPLE_BITS     (SAMPLE_BITS),
            .LANE_INDEX      (i)
        ) u_lane (
            .samples (win_sample),
            .mask    (win_mask),
            .rank    (lane_rank[i])
        );
    end

    always_comb
    begin
        win_count = '0;
        win_sum   = '0;
        for (int i = 0; i < WINDOW_ELEMENTS; i++)
        begin
            if (win_mask[i])
            begin
                win_count = win_count + CW'(1);
                win_sum   = win_sum + SW'(win_sample[i]);
            end
        end
    end

    // Stage 1: lane ranks, count and sum
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg [WINDOW_ELEMENTS];
    logic [WINDOW_ELEMENTS-1:0]    s1_mask_reg;
    logic [CW-1:0]                 s1_rank_reg [WINDOW_ELEMENTS];
    logic [CW-1:0]                 s1_count_reg;
    logic signed [SW-1:0]          s1_sum_reg;
    logic                          s1_take;
    logic                          s2_take;

    assign s1_take   = !s1_valid_reg || s2_take;
    assign win_stall = !s1_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && win_valid)
        begin
            s1_sample_reg <= win_sample;
            s1_mask_reg   <= win_mask;
            s1_rank_reg   <= lane_rank;
            s1_count_reg  <= win_count;
            s1_sum_reg    <= win_sum;
        end
    end

    // Stage 2: merge lanes
    pwr_ctrl_t                     m_ctrl;
    logic signed [SAMPLE_BITS-1:0] m_value;
    logic [QW-1:0]                 m_qd;
    logic [CW-1:0]                 m_div;

    pwr_merge #(
        .WINDOW_ELEMENTS (WINDOW_ELEMENTS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .QUOT_BITS       (QW)
    ) u_merge (
        .mode    (pool_mode_reg),
        .samples (s1_sample_reg),
        .mask    (s1_mask_reg),
        .ranks   (s1_rank_reg),
        .count   (s1_count_reg),
        .sum     (s1_sum_reg),
        .ctrl    (m_ctrl),
        .value   (m_value),
        .qd      (m_qd),
        .div     (m_div)
    );

    logic                          s2_valid_reg;
    pwr_ctrl_t                     s2_ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] s2_value_reg;
    logic [QW-1:0]                 s2_qd_reg;
    logic [CW-1:0]                 s2_div_reg;

    // Divider chain: index 0 is stage 2, index ND is the last divider stage
    logic                          c_valid [ND+1];
    logic                          c_take  [ND+1];
    pwr_ctrl_t                     c_ctrl  [ND+1];
    logic signed [SAMPLE_BITS-1:0] c_value [ND+1];
    logic [QW-1:0]                 c_qd    [ND+1];
    logic [CW-1:0]                 c_rem   [ND+1];
    logic [CW-1:0]                 c_div   [ND+1];

    assign s2_take = !s2_valid_reg || c_take[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s1_valid_reg)
        begin
            s2_ctrl_reg  <= m_ctrl;
            s2_value_reg <= m_value;
            s2_qd_reg    <= m_qd;
            s2_div_reg   <= m_div;
        end
    end

    assign c_valid[0] = s2_valid_reg;
    assign c_ctrl[0]  = s2_ctrl_reg;
    assign c_value[0] = s2_value_reg;
    assign c_qd[0]    = s2_qd_reg;
    assign c_rem[0]   = '0;
    assign c_div[0]   = s2_div_reg;

    for (genvar k = 0; k < ND; k++)
    begin : g_div
        pwr_div_stage #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .QUOT_BITS   (QW),
            .COUNT_BITS  (CW)
        ) u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[k]),
            .ready     (c_take[k]),
            .in_ctrl   (c_ctrl[k]),
            .in_value  (c_value[k]),
            .in_qd     (c_qd[k]),
            .in_rem    (c_rem[k]),
            .in_div    (c_div[k]),
            .out_valid (c_valid[k+1]),
            .take      (c_take[k+1]),
            .out_ctrl  (c_ctrl[k+1]),
            .out_value (c_value[k+1]),
            .out_qd    (c_qd[k+1]),
            .out_rem   (c_rem[k+1]),
            .out_div   (c_div[k+1])
        );
    end

    // Output register
    logic                          res_valid_reg;
    logic signed [SAMPLE_BITS-1:0] pooled_value_reg;
    logic                          window_empty_reg;
    logic signed [SAMPLE_BITS-1:0] pooled_value_next;
    logic [SAMPLE_BITS-1:0]        quot;

    assign c_take[ND] = !res_valid_reg || !res_stall;
    assign quot       = c_qd[ND][SAMPLE_BITS-1:0];

    always_comb
    begin
        if (c_ctrl[ND].empty)
        begin
            pooled_value_next = '0;
        end
        else if (c_ctrl[ND].avg)
        begin
            pooled_value_next = c_ctrl[ND].neg ? -quot : quot;
        end
        else
        begin
            pooled_value_next = c_value[ND];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (c_take[ND])
        begin
            res_valid_reg <= c_valid[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_take[ND] && c_valid[ND])
        begin
            pooled_value_reg <= pooled_value_next;
            window_empty_reg <= c_ctrl[ND].empty;
        end
    end

    assign res_valid    = res_valid_reg;
    assign pooled_value = pooled_value_reg;
    assign window_empty = window_empty_reg;

    // Lanes holding rank zero among the valid samples of stage 1
    logic [WINDOW_ELEMENTS-1:0] s1_rank_zero;

    always_comb
    begin
        for (int i = 0; i < WINDOW_ELEMENTS; i++)
        begin
            s1_rank_zero[i] = s1_mask_reg[i] && (s1_rank_reg[i] == '0);
        end
    end

    a_rank_unique: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_count_reg != '0 |-> $onehot(s1_rank_zero))
        else $error("lane ranks do not single out one minimum");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && window_empty |-> pooled_value == '0)
        else $error("empty window with nonzero result");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[ND] && c_ctrl[ND].avg && !c_ctrl[ND].empty |-> (c_qd[ND] >> SAMPLE_BITS) == '0)
        else $error("average quotient exceeds sample range");

    a_take_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !c_take[0] |=> s2_valid_reg)
        else $error("stage 2 transaction dropped while held");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pwr_pkg::*;

    localparam int WIN_ELEMS    = WINDOW_ELEMENTS_DEF;
    localparam int SMP_BITS     = SAMPLE_BITS_DEF;
    // extra wait after the last result so the pipeline of the block drains, with margin
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 100;

    typedef struct packed {
        logic [SAMPLE_FIELDS-1:0]               mask;
        logic [SAMPLE_FIELDS-1:0][SMP_BITS-1:0] smp;
    } window_t;

    typedef struct packed {
        logic [SMP_BITS-1:0] value;
        logic                empty;
    } pooled_t;

    logic                 clk;
    logic                 rst_n;
    logic                 pool_mode_we;
    logic [MODE_BITS-1:0] pool_mode_wdata;
    logic                 win_valid;
    logic                 win_stall;
    window_t              win_drv;
    logic                 res_valid;
    logic                 res_stall;
    logic [SMP_BITS-1:0]  pooled_value;
    logic                 window_empty;

    pool_mode_t cur_mode = MODE_MAX;
    bit         idle_on = 1'b1;
    pooled_t    pending_pools[$];
    int         mismatch_count = 0;

    pooling_window_reducer #(
        .WINDOW_ELEMENTS(WIN_ELEMS),
        .SAMPLE_BITS(SMP_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .pool_mode_we(pool_mode_we),
        .pool_mode_wdata(pool_mode_wdata),
        .win_valid(win_valid),
        .win_stall(win_stall),
        .sample_0(win_drv.smp[0]),
        .sample_1(win_drv.smp[1]),
        .sample_2(win_drv.smp[2]),
        .sample_3(win_drv.smp[3]),
        .sample_4(win_drv.smp[4]),
        .sample_5(win_drv.smp[5]),
        .sample_6(win_drv.smp[6]),
        .sample_7(win_drv.smp[7]),
        .sample_8(win_drv.smp[8]),
        .valid_mask(win_drv.mask),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .pooled_value(pooled_value),
        .window_empty(window_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pooled_t reduce_window(input window_t w, input pool_mode_t mode);
        int      vals[SAMPLE_FIELDS];
        int      count;
        int      sum;
        int      acc;
        int      key;
        int      i;
        int      j;
        pooled_t r;
        count = 0;
        sum   = 0;
        acc   = 0;
        for (i = 0; i < WIN_ELEMS; i++)
        begin
            if (w.mask[i])
            begin
                vals[count] = $signed(w.smp[i]);
                count++;
            end
        end
        if (count > 0)
        begin
            case (mode)
                MODE_MAX:
                begin
                    acc = vals[0];
                    for (i = 1; i < count; i++)
                        if (vals[i] > acc)
                            acc = vals[i];
                end
                MODE_MIN:
                begin
                    acc = vals[0];
                    for (i = 1; i < count; i++)
                        if (vals[i] < acc)
                            acc = vals[i];
                end
                MODE_AVG:
                begin
                    for (i = 0; i < count; i++)
                        sum += vals[i];
                    // int division truncates toward zero
                    acc = sum / count;
                end
                default:
                begin
                    for (i = 1; i < count; i++)
                    begin
                        key = vals[i];
                        j = i - 1;
                        while (j >= 0 && vals[j] > key)
                        begin
                            vals[j + 1] = vals[j];
                            j--;
                        end
                        vals[j + 1] = key;
                    end
                    // upper middle for an even count
                    acc = vals[count / 2];
                end
            endcase
        end
        r.value = acc[SMP_BITS-1:0];
        r.empty = (count == 0);
        return r;
    endfunction

    function automatic window_t mk_window(input logic [SAMPLE_FIELDS-1:0] m,
                                          input int v0, input int v1, input int v2,
                                          input int v3, input int v4, input int v5,
                                          input int v6, input int v7, input int v8);
        window_t w;
        w.mask   = m;
        w.smp[0] = v0[SMP_BITS-1:0];
        w.smp[1] = v1[SMP_BITS-1:0];
        w.smp[2] = v2[SMP_BITS-1:0];
        w.smp[3] = v3[SMP_BITS-1:0];
        w.smp[4] = v4[SMP_BITS-1:0];
        w.smp[5] = v5[SMP_BITS-1:0];
        w.smp[6] = v6[SMP_BITS-1:0];
        w.smp[7] = v7[SMP_BITS-1:0];
        w.smp[8] = v8[SMP_BITS-1:0];
        return w;
    endfunction

    function automatic window_t rand_window();
        window_t w;
        int      v;
        int      i;
        for (i = 0; i < SAMPLE_FIELDS; i++)
        begin
            case ($urandom_range(0, 7))
                0:       v = -32768;
                1:       v = 32767;
                2, 3:    v = int'($urandom_range(0, 8)) - 4;   // small range, many ties
                default: v = int'($urandom);
            endcase
            w.smp[i] = v[SMP_BITS-1:0];
        end
        case ($urandom_range(0, 9))
            0:       w.mask = '0;
            1:       w.mask = '1;
            2:       w.mask = SAMPLE_FIELDS'(1) << $urandom_range(0, SAMPLE_FIELDS - 1);
            default: w.mask = SAMPLE_FIELDS'($urandom);
        endcase
        return w;
    endfunction

    // called at a rising edge; returns at the edge where the transaction is accepted
    task automatic send_window(input window_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            win_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        win_valid <= 1'b1;
        win_drv   <= w;
        do
            @(posedge clk);
        while (win_stall);
        pending_pools = {pending_pools, reduce_window(w, cur_mode)};
    endtask

    // hold off the sender until every result is back and the pipeline is empty
    task automatic wait_idle();
        win_valid <= 1'b0;
        while (pending_pools.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input pool_mode_t m);
        pool_mode_we    <= 1'b1;
        pool_mode_wdata <= m;
        @(posedge clk);
        pool_mode_we    <= 1'b0;
        cur_mode = m;
    endtask

    task automatic test_directed_windows();
        pool_mode_t modes[4];
        int         k;
        modes = '{MODE_MAX, MODE_AVG, MODE_MEDIAN, MODE_MIN};
        for (k = 0; k < 4; k++)
        begin
            // the first pass runs on the reset value of the mode register
            if (k > 0)
            begin
                wait_idle();
                write_mode(modes[k]);
            end
            send_window(mk_window(9'h000, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767));
            send_window(mk_window(9'h1FF, -32768, 32767, 0, 1, -1, 256, -256, 100, -100));
            send_window(mk_window(9'h100, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, -32768));
            send_window(mk_window(9'h00F, 5, -3, 7, 1, 99, 99, 99, 99, 99));
            send_window(mk_window(9'h007, -3, -3, -1, 500, 500, 500, 500, 500, 500));
            send_window(mk_window(9'h1FF, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768));
        end
    endtask

    task automatic test_random_phases();
        pool_mode_t modes[5];
        int         k;
        int         n;
        modes = '{MODE_MIN, MODE_AVG, MODE_MAX, MODE_MEDIAN, MODE_AVG};
        idle_on = 1'b1;
        for (k = 0; k < 5; k++)
        begin
            wait_idle();
            write_mode(modes[k]);
            for (n = 0; n < RANDOM_ITEMS; n++)
                send_window(rand_window());
        end
    endtask

    task automatic test_back_to_back();
        int n;
        wait_idle();
        write_mode(pool_mode_t'($urandom_range(0, 3)));
        idle_on = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
            send_window(rand_window());
        idle_on = 1'b1;
    endtask

    // result side: draw a stall length after each result, compare in order
    initial
    begin
        int      stall_left;
        pooled_t want;
        stall_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (pending_pools.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: value %0d empty %0b",
                                 $signed(pooled_value), window_empty);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_pools.pop_front();
                    if (pooled_value !== want.value || window_empty !== want.empty)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: value exp %0d got %0d, empty exp %0b got %0b",
                                     $signed(want.value), $signed(pooled_value),
                                     want.empty, window_empty);
                        mismatch_count++;
                    end
                end
                stall_left = idle_on ? $urandom_range(0, 10) : 0;
            end
            else if (stall_left > 0)
                stall_left--;
            res_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        win_valid       <= 1'b0;
        win_drv         <= '0;
        pool_mode_we    <= 1'b0;
        pool_mode_wdata <= MODE_MAX;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_windows();
        test_random_phases();
        test_back_to_back();
        wait_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pwr_pkg.sv
rtl/pwr_lane.sv
rtl/pwr_merge.sv
rtl/pwr_div_stage.sv
rtl/pooling_window_reducer.sv
tb/sv/tb_top.sv
